// ----- rtl/progressive_shift_cipher_defines.svh -----
// Assertion helpers shared by the cipher RTL.
// Each macro expects clk and rst (synchronous, active high) in scope.
`ifndef PROGRESSIVE_SHIFT_CIPHER_DEFINES_SVH
`define PROGRESSIVE_SHIFT_CIPHER_DEFINES_SVH

// Same-cycle check: when ante holds, cons must hold at the same edge.
`define PSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: when ante holds, cons must hold at the next edge.
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/psc_pkg.sv -----
package psc_pkg;

  localparam int ALPHABET_SIZE = 30;
  localparam int IDX_W         = 5;
  localparam int CHAR_W        = 8;
  localparam int PROD_W        = 2 * IDX_W;
  localparam int SUM_W         = IDX_W + 1;
  localparam int RECIP_SHIFT   = PROD_W;
  localparam int RECIP         = (1 << RECIP_SHIFT) / ALPHABET_SIZE;
  localparam int RECIP_W       = $clog2(RECIP + 1);
  localparam int QUOT_W        = PROD_W + RECIP_W - RECIP_SHIFT;
  localparam int CFG_DATA_W    = IDX_W;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECRYPT_MODE   = 2'd0,
    CFG_SHIFT_AMOUNT   = 2'd1,
    CFG_STEP_INCREMENT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             decrypt_mode;
    logic [IDX_W-1:0] shift_amount;
    logic [IDX_W-1:0] step_increment;
  } psc_cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              bad_char;
  } psc_res_t;

  // Alphabet: space, a..z, period, question mark, comma.
  function automatic logic [CHAR_W-1:0] sym_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      5'd0:    c = 8'h20;
      5'd27:   c = 8'h2E;
      5'd28:   c = 8'h3F;
      5'd29:   c = 8'h2C;
      default: c = 8'h60 + CHAR_W'(idx);
    endcase
    return c;
  endfunction

  // Reduce a value below twice the alphabet size.
  function automatic logic [IDX_W-1:0] mod_small(input logic [SUM_W-1:0] x);
    logic [SUM_W-1:0] r;
    r = (x >= SUM_W'(ALPHABET_SIZE)) ? x - SUM_W'(ALPHABET_SIZE) : x;
    return r[IDX_W-1:0];
  endfunction

  // Reduce a product by reciprocal multiply; the quotient is at most one low.
  function automatic logic [IDX_W-1:0] mod_prod(input logic [PROD_W-1:0] x);
    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [QUOT_W-1:0]         q;
    logic [PROD_W:0]           qn;
    logic [PROD_W:0]           rem;
    scaled = {{RECIP_W{1'b0}}, x} * (PROD_W+RECIP_W)'(RECIP);
    q      = scaled[PROD_W+RECIP_W-1:RECIP_SHIFT];
    qn     = (PROD_W+1)'(q) * (PROD_W+1)'(ALPHABET_SIZE);
    rem    = {1'b0, x} - qn;
    return mod_small(rem[SUM_W-1:0]);
  endfunction

endpackage

// ----- rtl/psc_xform.sv -----
module psc_xform (
  input  logic [psc_pkg::CHAR_W-1:0] char_val,
  input  logic [psc_pkg::IDX_W-1:0]  pos,
  input  psc_pkg::psc_cfg_t          cfg,
  output psc_pkg::psc_res_t          res
);

  logic [psc_pkg::CHAR_W-1:0] folded;
  logic                       hit;
  logic [psc_pkg::IDX_W-1:0]  idx;
  logic [psc_pkg::IDX_W-1:0]  sh;
  logic [psc_pkg::IDX_W-1:0]  inc;
  logic [psc_pkg::PROD_W-1:0] prod;
  logic [psc_pkg::IDX_W-1:0]  step_off;
  logic [psc_pkg::IDX_W-1:0]  off;
  logic [psc_pkg::IDX_W-1:0]  enc_idx;
  logic [psc_pkg::IDX_W-1:0]  dec_idx;
  logic [psc_pkg::IDX_W-1:0]  out_idx;

  // Fold upper case only.
  assign folded = (char_val >= 8'h41 && char_val <= 8'h5A) ? char_val + 8'h20 : char_val;

  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int k = 0; k < psc_pkg::ALPHABET_SIZE; k++) begin
      if (folded == psc_pkg::sym_char(psc_pkg::IDX_W'(k))) begin
        hit = 1'b1;
        idx = psc_pkg::IDX_W'(k);
      end
    end
  end

  assign sh       = psc_pkg::mod_small({1'b0, cfg.shift_amount});
  assign inc      = psc_pkg::mod_small({1'b0, cfg.step_increment});
  assign prod     = {{psc_pkg::IDX_W{1'b0}}, pos} * {{psc_pkg::IDX_W{1'b0}}, inc};
  assign step_off = psc_pkg::mod_prod(prod);
  assign off      = psc_pkg::mod_small({1'b0, sh} + {1'b0, step_off});
  assign enc_idx  = psc_pkg::mod_small({1'b0, idx} + {1'b0, off});
  assign dec_idx  = psc_pkg::mod_small({1'b0, idx}
                    + psc_pkg::SUM_W'(psc_pkg::ALPHABET_SIZE) - {1'b0, off});
  assign out_idx  = cfg.decrypt_mode ? dec_idx : enc_idx;

  // Unknown symbols pass through raw, before folding.
  assign res.char_out = hit ? psc_pkg::sym_char(out_idx) : char_val;
  assign res.bad_char = ~hit;

endmodule

// ----- rtl/progressive_shift_cipher.sv -----
// Progressive shift cipher over a 30-symbol alphabet (space, a-z, '.', '?', ',').
// Input channel: in_valid / in_stall carry char_in and last_char. A beat is
//   taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry char_out, bad_char and
//   end_of_message, one result beat per input beat, in order.
// Config: cfg_we writes cfg_data into register cfg_index (0 decrypt_mode,
//   1 shift_amount, 2 step_increment); other indexes are ignored. Write only
//   while no beat is in flight.
// Pipeline: the input register captures an accepted beat, and the result register
//   loads its cipher result once out_ready allows; out_valid then rises. Throughput:
//   one beat per cycle while the output is not stalled; the whole cipher step
//   is one short combinational pass between the two registers.
// Stall: when the receiver stalls, the result register holds its beat, the
//   input register fills behind it, and in_stall rises once both are full.
// Reset (rst, synchronous): clears the pipeline valids, the message position
//   and all config registers to zero. Position restarts after a last_char beat.
`include "progressive_shift_cipher_defines.svh"

module progressive_shift_cipher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [psc_pkg::CHAR_W-1:0]     char_in,
  input  logic                           last_char,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [psc_pkg::CHAR_W-1:0]     char_out,
  output logic                           bad_char,
  output logic                           end_of_message
);

  psc_pkg::psc_cfg_t cfg;

  // Position of the next beat within its message.
  logic [psc_pkg::IDX_W-1:0]  pos;
  logic [psc_pkg::IDX_W-1:0]  pos_next;

  // Input register.
  logic                       s1_valid;
  logic [psc_pkg::CHAR_W-1:0] s1_char;
  logic                       s1_last;
  logic [psc_pkg::IDX_W-1:0]  s1_pos;

  logic                       out_ready;
  logic                       s1_adv;
  logic                       in_accept;
  psc_pkg::psc_res_t          xf;

  assign out_ready = ~out_valid | ~out_stall;
  assign s1_adv    = s1_valid & out_ready;
  assign in_stall  = s1_valid & ~out_ready;
  assign in_accept = in_valid & ~in_stall;

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        psc_pkg::CFG_DECRYPT_MODE:   cfg.decrypt_mode   <= cfg_data[0];
        psc_pkg::CFG_SHIFT_AMOUNT:   cfg.shift_amount   <= cfg_data;
        psc_pkg::CFG_STEP_INCREMENT: cfg.step_increment <= cfg_data;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Advance the position, wrap at the alphabet size, restart after a last beat.
  always_comb begin
    if (last_char || pos == psc_pkg::IDX_W'(psc_pkg::ALPHABET_SIZE - 1)) begin
      pos_next = '0;
    end else begin
      pos_next = pos + psc_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        pos      <= pos_next;
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Capture the beat along with the position it was taken at.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char <= char_in;
      s1_last <= last_char;
      s1_pos  <= pos;
    end
  end

  psc_xform u_xform (
    .char_val (s1_char),
    .pos      (s1_pos),
    .cfg      (cfg),
    .res      (xf)
  );

  // Result register: load on advance, clear once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      char_out       <= xf.char_out;
      bad_char       <= xf.bad_char;
      end_of_message <= s1_last;
    end
  end

  `PSC_ASSERT_NEXT(a_pos_restart, in_accept && last_char, pos == '0,
    "position did not restart after last beat")
  `PSC_ASSERT_NEXT(a_pos_step,
    in_accept && !last_char && pos != psc_pkg::IDX_W'(psc_pkg::ALPHABET_SIZE - 1),
    pos == $past(pos) + psc_pkg::IDX_W'(1), "position did not advance on accept")
  `PSC_ASSERT_NEXT(a_bad_passthru, s1_adv && xf.bad_char,
    bad_char && char_out == $past(s1_char), "unknown symbol not passed through")
  `PSC_ASSERT_NEXT(a_eom_follow, s1_adv, out_valid && end_of_message == $past(s1_last),
    "end_of_message lost on advance")
  `PSC_ASSERT_NOW(a_full_stalls, s1_valid && out_valid && out_stall, in_stall,
    "input taken while both registers held")

endmodule
